// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the converter modules; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition that holds at every clock edge out of reset
`define A2B_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define A2B_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define A2B_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define A2B_ASSERT(lbl, prop, msg)
`define A2B_ASSERT_IMP(lbl, ante, cons, msg)
`define A2B_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/a2b_pkg.sv
// ----------------------------------------------------------------------------
// a2b_pkg
// Types and constants of the AVCC to Annex B converter.
// ----------------------------------------------------------------------------
package a2b_pkg;

  // field widths
  localparam int BYTE_W      = 8;
  localparam int UNIT_LEN_W  = 24;
  // unit length arithmetic width (at most UNIT_LEN_W here)
  localparam int LENGTH_BITS = 24;
  localparam int NAL_LEN_W   = 32;

  // header gather depth and largest burst of words per input byte
  localparam int HOLD_DEPTH  = 4;
  localparam int BURST_MAX   = 8;

  localparam logic [NAL_LEN_W-1:0] ANNEXB_PREFIX = 32'h0000_0001;

  typedef logic [BYTE_W-1:0]                    byte_t;
  typedef logic [LENGTH_BITS-1:0]               len_t;
  typedef logic [NAL_LEN_W-1:0]                 nal_t;
  typedef logic [$clog2(HOLD_DEPTH+1)-1:0]      hold_cnt_t;
  typedef logic [$clog2(HOLD_DEPTH)-1:0]        hold_idx_t;
  typedef logic [$clog2(BURST_MAX+1)-1:0]       burst_cnt_t;
  typedef logic [BURST_MAX-1:0][BYTE_W-1:0]     burst_words_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_GATHER  = 2'd1,
    MODE_PAYLOAD = 2'd2,
    MODE_PASS    = 2'd3
  } walk_mode_t;

  typedef enum logic [1:0] {
    KIND_SHORT   = 2'd0,
    KIND_ANNEXB  = 2'd1,
    KIND_AVCC    = 2'd2,
    KIND_PREPEND = 2'd3
  } unit_kind_t;

  // burst handed from the step logic to the output register
  typedef struct packed {
    logic         valid;
    burst_cnt_t   count;
    burst_words_t words;
    logic         last;
    unit_kind_t   kind;
  } a2b_load_t;

endpackage

// File: rtl/a2b_in_if.sv
// ----------------------------------------------------------------------------
// a2b_in_if
// Input channel: one access-unit byte per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface a2b_in_if import a2b_pkg::*; ();

  logic                  valid;
  logic                  ready;
  logic [BYTE_W-1:0]     data_byte;
  logic [UNIT_LEN_W-1:0] unit_length;
  logic                  first_of_unit;

  modport source (output valid, output data_byte, output unit_length,
                  output first_of_unit, input ready);
  modport sink   (input valid, input data_byte, input unit_length,
                  input first_of_unit, output ready);

endinterface

// File: rtl/a2b_out_if.sv
// ----------------------------------------------------------------------------
// a2b_out_if
// Result channel: one Annex B byte per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface a2b_out_if import a2b_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_unit;
  logic [1:0]        unit_kind;

  modport source (output valid, output out_byte, output last_of_unit,
                  output unit_kind, input ready);
  modport sink   (input valid, input out_byte, input last_of_unit,
                  input unit_kind, output ready);

endinterface

// File: rtl/avcc_to_annexb_converter.sv
// ----------------------------------------------------------------------------
// avcc_to_annexb_converter
// H.264 access-unit converter from AVCC length framing to Annex B start codes.
// ----------------------------------------------------------------------------
// Bytes enter one word per cycle while the input is ready and are registered;
// the combinational walk logic then decides what the byte produces and loads
// it into an eight-word output register, which the result channel drains one
// word per cycle while it is ready. A passed byte therefore goes through the
// input register and the output register before it is offered at the output,
// and bytes flow at one per cycle when the output does not stall. The four
// bytes of each length header produce nothing until the fourth, which loads a
// burst of four words (eight when a start code is put in front of the unit);
// while that burst drains, input stalls. The output register draining one
// word per cycle is what sets the rate.
// ----------------------------------------------------------------------------
module avcc_to_annexb_converter import a2b_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  a2b_in_if.sink    in_ch,
  a2b_out_if.source out_ch
);

  a2b_load_t load;
  logic      load_ready;

  // walk logic behind the input register
  a2b_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .load_ready (load_ready),
    .load_o     (load)
  );

  // output burst register
  a2b_burst u_burst (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (load),
    .load_ready (load_ready),
    .out_ch     (out_ch)
  );

endmodule

// File: rtl/a2b_step.sv
// ----------------------------------------------------------------------------
// a2b_step
// Input register and per-byte walk logic: tracks the unit, gathers length
// headers and produces the burst of output words for each input byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module a2b_step import a2b_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  a2b_in_if.sink    in_ch,
  input  logic      load_ready,
  output a2b_load_t load_o
);

  // input register
  logic       in_valid_r;
  byte_t      in_byte_r;
  len_t       in_len_r;
  logic       in_first_r;
  logic       advance;

  // walk state
  len_t       pos_r, pos_nxt;
  len_t       lat_r, lat_nxt;
  len_t       pl_r, pl_nxt;
  hold_cnt_t  hc_r, hc_nxt;
  walk_mode_t mode_r, mode_nxt, mode_cur;
  unit_kind_t kind_r, kind_nxt;
  byte_t      hold_r [HOLD_DEPTH];

  // step logic
  byte_t        hold_cur [HOLD_DEPTH];
  logic         hold_we;
  hold_idx_t    hold_idx;
  nal_t         nal;
  logic         nal_ok;
  logic         annexb;
  logic         unit_end;
  logic         active;
  burst_cnt_t   word_cnt;
  burst_words_t words;

  assign advance     = in_valid_r && load_ready;
  assign in_ch.ready = !in_valid_r || load_ready;

  // input register, refilled whenever it empties
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r  <= in_ch.data_byte;
      in_len_r   <= in_ch.unit_length[LENGTH_BITS-1:0];
      in_first_r <= in_ch.first_of_unit;
    end
  end

  // walk of one byte
  always_comb begin
    lat_nxt  = lat_r;
    pos_nxt  = pos_r;
    pl_nxt   = pl_r;
    hc_nxt   = hc_r;
    mode_cur = mode_r;
    kind_nxt = kind_r;
    hold_cur = hold_r;
    hold_we  = 1'b0;
    hold_idx = hc_r[$clog2(HOLD_DEPTH)-1:0];
    nal      = '0;
    nal_ok   = 1'b0;
    annexb   = 1'b0;
    unit_end = 1'b0;
    word_cnt = '0;
    words    = '0;

    // a new unit restarts the walk
    if (in_first_r) begin
      lat_nxt  = in_len_r;
      pos_nxt  = '0;
      pl_nxt   = '0;
      hc_nxt   = '0;
      kind_nxt = KIND_SHORT;
      if (in_len_r == '0) begin
        mode_cur = MODE_IDLE;
      end else if (in_len_r <= len_t'(HOLD_DEPTH)) begin
        mode_cur = MODE_PASS;
      end else begin
        mode_cur = MODE_GATHER;
      end
      active = (in_len_r != '0);
    end else begin
      active = (mode_r != MODE_IDLE);
    end
    mode_nxt = mode_cur;

    if (active) begin
      pos_nxt  = pos_nxt + len_t'(1);
      unit_end = (pos_nxt == lat_nxt);
      case (mode_cur)
        MODE_PASS: begin
          word_cnt = burst_cnt_t'(1);
          words[0] = in_byte_r;
        end
        MODE_PAYLOAD: begin
          word_cnt = burst_cnt_t'(1);
          words[0] = in_byte_r;
          if (pl_nxt != '0) begin
            pl_nxt = pl_nxt - len_t'(1);
          end
          // end of this NAL: look for the next length field
          if (pl_nxt == '0 && !unit_end) begin
            mode_nxt = ((lat_nxt - pos_nxt) >= len_t'(HOLD_DEPTH)) ? MODE_GATHER : MODE_PASS;
            hc_nxt   = '0;
          end
        end
        MODE_GATHER: begin
          hold_idx           = hc_nxt[$clog2(HOLD_DEPTH)-1:0];
          hold_we            = 1'b1;
          hold_cur[hold_idx] = in_byte_r;
          hc_nxt             = hc_nxt + hold_cnt_t'(1);
          if (hc_nxt >= hold_cnt_t'(HOLD_DEPTH) || unit_end) begin
            hc_nxt = '0;
            nal    = {hold_cur[0], hold_cur[1], hold_cur[2], hold_cur[3]};
            nal_ok = (nal != '0) &&
                     ((33'(pos_nxt) + 33'(nal)) <= 33'(lat_nxt));
            annexb = (nal == ANNEXB_PREFIX) ||
                     (nal[NAL_LEN_W-1:BYTE_W] == ANNEXB_PREFIX[NAL_LEN_W-BYTE_W-1:0]);
            if (pos_nxt == len_t'(HOLD_DEPTH)) begin
              // first header of the unit decides the kind
              if (annexb) begin
                kind_nxt = KIND_ANNEXB;
                word_cnt = burst_cnt_t'(HOLD_DEPTH);
                for (int i = 0; i < HOLD_DEPTH; i++) words[i] = hold_cur[i];
                mode_nxt = MODE_PASS;
              end else if (nal_ok) begin
                kind_nxt = KIND_AVCC;
                word_cnt = burst_cnt_t'(HOLD_DEPTH);
                for (int i = 0; i < HOLD_DEPTH; i++) begin
                  words[i] = ANNEXB_PREFIX[BYTE_W*(HOLD_DEPTH-1-i) +: BYTE_W];
                end
                pl_nxt   = nal[LENGTH_BITS-1:0];
                mode_nxt = MODE_PAYLOAD;
              end else begin
                kind_nxt = KIND_PREPEND;
                word_cnt = burst_cnt_t'(2 * HOLD_DEPTH);
                for (int i = 0; i < HOLD_DEPTH; i++) begin
                  words[i]              = ANNEXB_PREFIX[BYTE_W*(HOLD_DEPTH-1-i) +: BYTE_W];
                  words[HOLD_DEPTH + i] = hold_cur[i];
                end
                mode_nxt = MODE_PASS;
              end
            end else if (nal_ok) begin
              word_cnt = burst_cnt_t'(HOLD_DEPTH);
              for (int i = 0; i < HOLD_DEPTH; i++) begin
                words[i] = ANNEXB_PREFIX[BYTE_W*(HOLD_DEPTH-1-i) +: BYTE_W];
              end
              pl_nxt   = nal[LENGTH_BITS-1:0];
              mode_nxt = MODE_PAYLOAD;
            end else begin
              // bad length: rest of the unit passes unchanged
              word_cnt = burst_cnt_t'(HOLD_DEPTH);
              for (int i = 0; i < HOLD_DEPTH; i++) words[i] = hold_cur[i];
              mode_nxt = MODE_PASS;
            end
          end
        end
        default: ;
      endcase
      if (unit_end) begin
        mode_nxt = MODE_IDLE;
      end
    end
  end

  // walk state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      lat_r  <= '0;
      pl_r   <= '0;
      hc_r   <= '0;
      mode_r <= MODE_IDLE;
      kind_r <= KIND_SHORT;
    end else if (advance) begin
      pos_r  <= pos_nxt;
      lat_r  <= lat_nxt;
      pl_r   <= pl_nxt;
      hc_r   <= hc_nxt;
      mode_r <= mode_nxt;
      kind_r <= kind_nxt;
    end
  end

  // header bytes
  always_ff @(posedge clk) begin
    if (advance && hold_we) begin
      hold_r[hold_idx] <= in_byte_r;
    end
  end

  // burst towards the output register
  always_comb begin
    load_o.valid = advance && (word_cnt != '0);
    load_o.count = word_cnt;
    load_o.words = words;
    load_o.last  = unit_end;
    load_o.kind  = kind_nxt;
  end

  `A2B_ASSERT_IMP(step_burst_size, load_o.valid,
                  load_o.count == burst_cnt_t'(1) || load_o.count == burst_cnt_t'(HOLD_DEPTH) ||
                  load_o.count == burst_cnt_t'(2 * HOLD_DEPTH), "step: burst size not 1, 4 or 8")
  `A2B_ASSERT_IMP(step_payload_left, mode_r == MODE_PAYLOAD, pl_r != '0,
                  "step: payload mode with nothing left")
  `A2B_ASSERT_IMP(step_hold_count, mode_r == MODE_GATHER, hc_r < hold_cnt_t'(HOLD_DEPTH),
                  "step: header hold overfull")

endmodule

// File: rtl/a2b_burst.sv
// ----------------------------------------------------------------------------
// a2b_burst
// Output register holding one burst of up to eight words, shifted out one
// word per handshake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module a2b_burst import a2b_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  a2b_load_t load_i,
  output logic      load_ready,
  a2b_out_if.source out_ch
);

  burst_words_t words_r;
  burst_cnt_t   cnt_r;
  logic         last_r;
  unit_kind_t   kind_r;
  logic         take;

  assign take       = out_ch.valid && out_ch.ready;
  // free now, or freed by the word leaving this cycle
  assign load_ready = (cnt_r == '0) || (cnt_r == burst_cnt_t'(1) && out_ch.ready);

  // word count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load_i.valid) begin
      cnt_r <= load_i.count;
    end else if (take) begin
      cnt_r <= cnt_r - burst_cnt_t'(1);
    end
  end

  // burst words, shifted towards word 0
  always_ff @(posedge clk) begin
    if (load_i.valid) begin
      words_r <= load_i.words;
      last_r  <= load_i.last;
      kind_r  <= load_i.kind;
    end else if (take) begin
      words_r <= {byte_t'(0), words_r[BURST_MAX-1:1]};
    end
  end

  // result channel
  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.out_byte     = words_r[0];
  assign out_ch.last_of_unit = last_r && (cnt_r == burst_cnt_t'(1));
  assign out_ch.unit_kind    = kind_r;

  `A2B_ASSERT(burst_cnt_range, cnt_r <= burst_cnt_t'(BURST_MAX), "burst: word count out of range")
  `A2B_ASSERT_IMP(burst_no_overwrite, load_i.valid, cnt_r == '0 || (cnt_r == burst_cnt_t'(1) && take), "burst: load over undelivered words")
  `A2B_ASSERT_NXT(burst_drain, take && !load_i.valid, cnt_r == $past(cnt_r) - burst_cnt_t'(1), "burst: word count did not step down")

endmodule

// File: sim/annexb_stream_checker.sv
// ----------------------------------------------------------------------------
// annexb_stream_checker
// Watches both channels of the converter, works out the Annex B words each
// accepted input byte should give and compares them in order with the
// words that leave the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module annexb_stream_checker import a2b_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  a2b_in_if    in_ch,
  a2b_out_if   out_ch,
  output int   fail_count,
  output int   words_owed
);

  typedef struct packed {
    byte_t      data;
    logic       last;
    unit_kind_t kind;
  } annexb_word_t;

  // expected output words, oldest first
  annexb_word_t annexb_q[$];
  int errs = 0;

  // converter state
  len_t       unit_len;
  len_t       taken;
  len_t       nal_left;
  byte_t      hdr_bytes [HOLD_DEPTH];
  logic [2:0] hdr_fill;
  walk_mode_t walk;
  unit_kind_t kind;

  function automatic void push_word(input byte_t data, input logic end_mark);
    annexb_q.push_back('{data: data, last: end_mark, kind: kind});
  endfunction

  // four bytes msb first, end mark only on the fourth
  function automatic void push_four(input nal_t w, input logic end_mark);
    for (int i = 0; i < 4; i++)
      push_word(w[31-8*i -: 8], (i == 3) ? end_mark : 1'b0);
  endfunction

  // one accepted input byte: update the walk and queue what it produces
  function automatic void convert_byte(input byte_t data,
                                       input logic [UNIT_LEN_W-1:0] len_in,
                                       input logic first);
    logic at_end;
    logic nal_ok;
    logic annexb_hdr;
    nal_t hdr_word;
    if (first) begin
      unit_len = len_t'(len_in);
      taken    = '0;
      nal_left = '0;
      hdr_fill = '0;
      kind     = KIND_SHORT;
      if (unit_len == '0) begin
        walk = MODE_IDLE;
        return;
      end
      walk = (unit_len <= len_t'(4)) ? MODE_PASS : MODE_GATHER;
    end else if (walk == MODE_IDLE) begin
      return;
    end

    taken  = taken + len_t'(1);
    at_end = (taken == unit_len);

    case (walk)
      MODE_PASS: push_word(data, at_end);
      MODE_PAYLOAD: begin
        push_word(data, at_end);
        if (nal_left != '0) nal_left = nal_left - len_t'(1);
        if (nal_left == '0 && !at_end) begin
          walk     = ((unit_len - taken) >= len_t'(4)) ? MODE_GATHER : MODE_PASS;
          hdr_fill = '0;
        end
      end
      default: begin
        // gather the 4-byte length header
        hdr_bytes[hdr_fill[1:0]] = data;
        hdr_fill = hdr_fill + 3'd1;
        if (hdr_fill < 3'(HOLD_DEPTH) && !at_end) return;
        hdr_fill = '0;
        hdr_word = {hdr_bytes[0], hdr_bytes[1], hdr_bytes[2], hdr_bytes[3]};
        nal_ok = (hdr_word != '0) &&
                 (({1'b0, hdr_word} + 33'(taken)) <= 33'(unit_len));
        if (taken == len_t'(4)) begin
          annexb_hdr = (hdr_word == ANNEXB_PREFIX) ||
                       (hdr_word[31:8] == ANNEXB_PREFIX[23:0]);
          if (annexb_hdr) begin
            kind = KIND_ANNEXB;
            push_four(hdr_word, at_end);
            walk = MODE_PASS;
          end else if (nal_ok) begin
            kind = KIND_AVCC;
            push_four(ANNEXB_PREFIX, 1'b0);
            nal_left = len_t'(hdr_word);
            walk = MODE_PAYLOAD;
          end else begin
            // bad first length: start code in front of the whole unit
            kind = KIND_PREPEND;
            push_four(ANNEXB_PREFIX, 1'b0);
            push_four(hdr_word, at_end);
            walk = MODE_PASS;
          end
        end else if (nal_ok) begin
          push_four(ANNEXB_PREFIX, 1'b0);
          nal_left = len_t'(hdr_word);
          walk = MODE_PAYLOAD;
        end else begin
          push_four(hdr_word, at_end);
          walk = MODE_PASS;
        end
      end
    endcase

    if (at_end) walk = MODE_IDLE;
  endfunction

  // compare one output word with the oldest expectation
  function automatic void check_word();
    annexb_word_t want;
    if (annexb_q.size() == 0) begin
      $error("unexpected word: out_byte %0h last_of_unit %0b unit_kind %0d",
             out_ch.out_byte, out_ch.last_of_unit, out_ch.unit_kind);
      errs++;
      return;
    end
    want = annexb_q.pop_front();
    if (out_ch.out_byte !== want.data) begin
      $error("out_byte: expected %0h actual %0h", want.data, out_ch.out_byte);
      errs++;
    end
    if (out_ch.last_of_unit !== want.last) begin
      $error("last_of_unit: expected %0b actual %0b", want.last, out_ch.last_of_unit);
      errs++;
    end
    if (out_ch.unit_kind !== want.kind) begin
      $error("unit_kind: expected %0d actual %0d", want.kind, out_ch.unit_kind);
      errs++;
    end
  endfunction

  // output is checked before the input of the same edge is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      unit_len = '0;
      taken    = '0;
      nal_left = '0;
      hdr_fill = '0;
      walk     = MODE_IDLE;
      kind     = KIND_SHORT;
      annexb_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) check_word();
      if (in_ch.valid && in_ch.ready)
        convert_byte(in_ch.data_byte, in_ch.unit_length, in_ch.first_of_unit);
    end
    fail_count <= errs;
    words_owed <= annexb_q.size();
  end

endmodule

// File: sim/avcc_to_annexb_converter_tb.sv
// ----------------------------------------------------------------------------
// avcc_to_annexb_converter_tb
// Feeds the converter directed and random access units (AVCC, Annex B,
// short, bad first length, zero length, abandoned units and stray bytes)
// with random idling on both channels and one long output hold-off; the
// checker beside the block predicts and compares every output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module avcc_to_annexb_converter_tb;
  import a2b_pkg::*;

  localparam int RANDOM_WORDS    = 180;
  localparam int CALM_WORDS      = 40;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 24;
  localparam int CYCLE_LIMIT     = 250000;

  typedef struct packed {
    byte_t                 data;
    logic [UNIT_LEN_W-1:0] len;
    logic                  first;
  } in_word_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   words_owed;
  int   cycle_count;
  int   unit_words;
  int   directed_words;
  logic calm = 1'b0;
  logic hold_off_req = 1'b0;

  byte_t    unit_q[$];
  in_word_t stim_q[$];

  a2b_in_if  in_ch ();
  a2b_out_if out_ch ();

  avcc_to_annexb_converter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  annexb_stream_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .words_owed (words_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- stimulus

  function automatic void push_be32(input nal_t v);
    for (int i = 0; i < 4; i++) unit_q.push_back(v[31-8*i -: 8]);
  endfunction

  function automatic void push_payload(input int n);
    for (int i = 0; i < n; i++) unit_q.push_back(byte_t'($urandom()));
  endfunction

  // send the first count bytes of the built unit, length on the first byte
  function automatic void emit_unit(input int claimed, input int count);
    for (int i = 0; i < count; i++)
      stim_q.push_back('{data: unit_q[i],
                         len: (i == 0) ? UNIT_LEN_W'(claimed) : UNIT_LEN_W'($urandom()),
                         first: (i == 0)});
    if (claimed != 0) unit_words += count;
    unit_q.delete();
  endfunction

  // bytes with no first mark, dropped while the block is idle
  function automatic void push_strays(input int n);
    for (int i = 0; i < n; i++)
      stim_q.push_back('{data: byte_t'($urandom()), len: UNIT_LEN_W'($urandom()),
                         first: 1'b0});
  endfunction

  function automatic void build_directed();
    // zero-length unit, then a byte outside any unit
    unit_q.push_back(8'hA5);
    emit_unit(0, 1);
    push_strays(1);
    // shortest and longest passthrough units
    unit_q.push_back(8'hFF);
    emit_unit(1, 1);
    unit_q = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    emit_unit(4, 4);
    // already Annex B, 4-byte and 3-byte start codes
    push_be32(ANNEXB_PREFIX);
    unit_q.push_back(8'h65);
    unit_q.push_back(8'hAA);
    emit_unit(6, 6);
    unit_q = '{8'h00, 8'h00, 8'h01, 8'h09, 8'hF0};
    emit_unit(5, 5);
    // one AVCC NAL
    push_be32(32'd2);
    unit_q.push_back(8'hAB);
    unit_q.push_back(8'hCD);
    emit_unit(6, 6);
    // oversize first length field: start code prepended
    push_be32(32'hFFFF_FFFF);
    unit_q.push_back(8'h00);
    emit_unit(5, 5);
    // largest length, abandoned by a new unit
    unit_q.push_back(8'h3C);
    emit_unit('hFF_FFFF, 1);
    unit_q = '{8'h12, 8'h34};
    emit_unit(2, 2);
  endfunction

  function automatic void add_random_unit();
    int pick;
    int nals;
    int n;
    int count;
    pick = $urandom_range(0, 99);
    unit_q.delete();
    if (pick < 50) begin
      // well-formed AVCC, sometimes with a broken tail
      nals = $urandom_range(1, 3);
      for (int k = 0; k < nals; k++) begin
        n = (k == 0) ? $urandom_range(2, 9) : $urandom_range(1, 9);
        push_be32(nal_t'(n));
        push_payload(n);
      end
      case ($urandom_range(0, 5))
        2: push_payload($urandom_range(1, 3));
        3: begin
          push_be32('0);
          push_payload($urandom_range(0, 3));
        end
        4: begin
          push_be32(nal_t'($urandom_range(100, 255)));
          push_payload($urandom_range(0, 3));
        end
        5: begin
          push_be32($urandom() | 32'h8000_0000);
          push_payload($urandom_range(0, 3));
        end
        default: ;
      endcase
      emit_unit(unit_q.size(), unit_q.size());
    end else if (pick < 62) begin
      // already Annex B
      if ($urandom_range(0, 1)) push_be32(ANNEXB_PREFIX);
      else unit_q = '{8'h00, 8'h00, 8'h01};
      push_payload($urandom_range(2, 15));
      emit_unit(unit_q.size(), unit_q.size());
    end else if (pick < 72) begin
      // bad first length: zero, overrunning or oversize
      case ($urandom_range(0, 2))
        0:       push_be32('0);
        1:       push_be32(nal_t'($urandom_range(100, 255)));
        default: push_be32($urandom() | 32'h8000_0000);
      endcase
      push_payload($urandom_range(1, 12));
      emit_unit(unit_q.size(), unit_q.size());
    end else if (pick < 80) begin
      push_payload($urandom_range(1, 4));
      emit_unit(unit_q.size(), unit_q.size());
    end else if (pick < 88) begin
      // unit cut short by the next first byte
      count = $urandom_range(1, 12);
      push_be32(nal_t'($urandom_range(1, 6)));
      push_payload(8);
      emit_unit($urandom_range(count + 1, 'hFF_FFFF), count);
    end else if (pick < 94) begin
      unit_q.push_back(byte_t'($urandom()));
      emit_unit(0, 1);
      push_strays($urandom_range(0, 3));
    end else begin
      push_strays($urandom_range(1, 3));
    end
  endfunction

  // ----------------------------------------------------------------- sender

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.data_byte     <= '0;
    in_ch.unit_length   <= '0;
    in_ch.first_of_unit <= 1'b0;
    rst_n               <= 1'b0;
    unit_words = 0;
    build_directed();
    directed_words = stim_q.size();
    unit_words = 0;
    while (unit_words < RANDOM_WORDS) add_random_unit();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < stim_q.size(); i++) begin
      if (i == directed_words) hold_off_req = 1'b1;
      calm = (stim_q.size() - i) <= CALM_WORDS;
      // random gap before the word
      if (!calm && $urandom_range(0, 5) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      in_ch.valid         <= 1'b1;
      in_ch.data_byte     <= stim_q[i].data;
      in_ch.unit_length   <= stim_q[i].len;
      in_ch.first_of_unit <= stim_q[i].first;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
    end
    in_ch.valid <= 1'b0;

    // let the checker catch up, then drain what is left
    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("avcc_to_annexb_converter_tb passed");
    else
      $display("avcc_to_annexb_converter_tb failed");
    $finish;
  end

  // --------------------------------------------------------------- receiver

  initial begin
    int  stall_left;
    logic held_off;
    stall_left = 0;
    held_off   = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      // one long hold-off so the block backs up into its input
      if (hold_off_req && !held_off) begin
        held_off   = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- timeout

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("avcc_to_annexb_converter_tb failed");
    $finish;
  end

endmodule
